[rtl/pcan_pkg.sv]
`default_nettype none

package pcan_pkg;

    // field widths of the stream words
    localparam int OP_W      = 2;
    localparam int CH_W      = 8;
    localparam int RIDX_W    = 10;
    localparam int PL_W      = 11;
    localparam int S_FIELD_W = OP_W + CH_W + RIDX_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = CH_W + PL_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // default buffer size
    localparam int MAX_PATH_LEN_DEF = 1024;

    // path bytes with a meaning
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

    // item operations
    typedef enum logic [OP_W-1:0] {
        OP_CHAR   = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // what the current component holds so far
    typedef enum logic [1:0] {
        KIND_SLASH  = 2'd0,
        KIND_DOT    = 2'd1,
        KIND_DOTDOT = 2'd2,
        KIND_NAME   = 2'd3
    } t_kind;

endpackage

`default_nettype wire

[rtl/path_canonicalizer_top.sv]
// channel  | dir | tdata fields (lsb first)                        | handshake
// ---------+-----+-------------------------------------------------+------------------
// s_axis   | in  | op[1:0] char_in[9:2] read_index[19:10] pad 0     | tvalid / tready
// m_axis   | out | char_out[7:0] path_length[18:8] overflow[19]     | tvalid / tready
//
// an item walks the engine states: read, clear, dot and plain close go idle to done,
// a '..' close passes pop, a name byte passes write, and a new component writes slash,
// held-back dots and the byte in turn; the single byte-wide write port of the buffer sets this.
// a one-entry input register and an output register let the next word enter while
// a result waits. synchronous active-low reset clears control state only; buffer
// and slash table hold garbage until written and need no clearing pass.
`default_nettype none

module path_canonicalizer_top #(
    parameter int MAX_PATH_LEN = pcan_pkg::MAX_PATH_LEN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // op, char_in, read_index, zero pad
    input  wire logic [pcan_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // char_out, path_length, overflow, zero pad
    output logic [pcan_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import pcan_pkg::*;

    localparam int LW    = $clog2(MAX_PATH_LEN + 1);
    localparam int AW    = $clog2(MAX_PATH_LEN);
    localparam int SLOTS = MAX_PATH_LEN / 2;
    localparam int SAW   = $clog2(SLOTS);
    localparam int DEPW  = $clog2(SLOTS + 1);
    localparam int XW    = (LW > RIDX_W) ? LW : RIDX_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POP   = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // input holding register
    logic              r_in_valid;
    t_op               r_in_op;
    logic [CH_W-1:0]   r_in_ch;
    logic [RIDX_W-1:0] r_in_idx;

    // engine state
    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [DEPW-1:0]   r_depth, n_depth;
    logic [LW-1:0]     r_len, n_len;
    logic              r_ovf, n_ovf;
    logic              r_need_slash, n_need_slash;
    logic [1:0]        r_dots, n_dots;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic              r_fin, n_fin;
    logic              r_rd_ok, n_rd_ok;

    // output register
    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_char;
    logic [LW-1:0]     r_out_len;
    logic              r_out_ovf;

    // memories and their ports
    logic [CH_W-1:0]   buf_mem [MAX_PATH_LEN];
    logic [AW-1:0]     slash_mem [SLOTS];
    logic [CH_W-1:0]   r_buf_q;
    logic [AW-1:0]     r_slash_q;
    logic              buf_we, buf_re, slash_we, slash_re;
    logic [AW-1:0]     buf_wa, buf_ra;
    logic [CH_W-1:0]   buf_wd;
    logic [SAW-1:0]    slash_wa, slash_ra;

    logic              take;
    logic              out_load;
    logic [DEPW-1:0]   depth_dec;
    logic [XW-1:0]     idx_x, len_x;

    assign take            = (r_state == ST_IDLE) && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || take;
    assign out_load        = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
    assign depth_dec       = r_depth - DEPW'(1);
    assign idx_x           = XW'(r_in_idx);
    assign len_x           = XW'(r_len);

    // input holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op  <= t_op'(i_s_axis_tdata[OP_W-1:0]);
            r_in_ch  <= i_s_axis_tdata[OP_W+CH_W-1:OP_W];
            r_in_idx <= i_s_axis_tdata[S_FIELD_W-1:OP_W+CH_W];
        end
    end

    // sequencer: decode, pop, byte writes
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_depth      = r_depth;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_need_slash = r_need_slash;
        n_dots       = r_dots;
        n_ch         = r_ch;
        n_fin        = r_fin;
        n_rd_ok      = r_rd_ok;
        buf_we       = 1'b0;
        buf_wa       = r_len[AW-1:0];
        buf_wd       = r_ch;
        buf_re       = 1'b0;
        buf_ra       = idx_x[AW-1:0];
        slash_we     = 1'b0;
        slash_wa     = r_depth[SAW-1:0];
        slash_re     = 1'b0;
        slash_ra     = depth_dec[SAW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_rd_ok      = 1'b0;
                    n_fin        = 1'b0;
                    n_need_slash = 1'b0;
                    n_dots       = 2'd0;
                    n_ch         = r_in_ch;
                    n_state      = ST_DONE;
                    case (r_in_op)
                        OP_CHAR: begin
                            if (r_in_ch == CH_SLASH) begin
                                n_kind = KIND_SLASH;
                                if (r_kind == KIND_DOTDOT && r_depth != '0) begin
                                    slash_re = 1'b1;
                                    n_depth  = depth_dec;
                                    n_state  = ST_POP;
                                end
                            end else if (r_in_ch == CH_DOT && r_kind == KIND_SLASH) begin
                                n_kind = KIND_DOT;
                            end else if (r_in_ch == CH_DOT && r_kind == KIND_DOT) begin
                                n_kind = KIND_DOTDOT;
                            end else begin
                                // a new component brings its slash and held-back dots
                                if (r_kind != KIND_NAME) begin
                                    n_need_slash = 1'b1;
                                    n_dots       = r_kind;
                                end
                                n_kind  = KIND_NAME;
                                n_state = ST_WRITE;
                            end
                        end
                        OP_FINISH: begin
                            n_kind = KIND_SLASH;
                            n_ch   = CH_SLASH;
                            if (r_kind == KIND_DOTDOT && r_depth != '0) begin
                                slash_re = 1'b1;
                                n_depth  = depth_dec;
                                n_fin    = 1'b1;
                                n_state  = ST_POP;
                            end else if (r_len == '0) begin
                                n_state = ST_WRITE;
                            end
                        end
                        OP_READ: begin
                            buf_re  = 1'b1;
                            n_rd_ok = idx_x < len_x;
                        end
                        OP_CLEAR: begin
                            n_depth = '0;
                            n_len   = '0;
                            n_kind  = KIND_SLASH;
                            n_ovf   = 1'b0;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                // length falls back to the slash of the removed component
                n_len = LW'(r_slash_q);
                if (r_fin && r_slash_q == '0) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WRITE: begin
                if (r_need_slash) begin
                    n_need_slash = 1'b0;
                    if (r_depth >= DEPW'(SLOTS) || r_len >= LW'(MAX_PATH_LEN)) begin
                        n_ovf = 1'b1;
                    end else begin
                        slash_we = 1'b1;
                        buf_we   = 1'b1;
                        buf_wd   = CH_SLASH;
                        n_depth  = r_depth + DEPW'(1);
                        n_len    = r_len + LW'(1);
                    end
                end else begin
                    if (r_dots != 2'd0) begin
                        buf_wd = CH_DOT;
                        n_dots = r_dots - 2'd1;
                    end else begin
                        n_state = ST_DONE;
                    end
                    if (r_len < LW'(MAX_PATH_LEN)) begin
                        buf_we = 1'b1;
                        n_len  = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // engine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_SLASH;
            r_depth <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_depth <= n_depth;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
        end
        r_need_slash <= n_need_slash;
        r_dots       <= n_dots;
        r_ch         <= n_ch;
        r_fin        <= n_fin;
        r_rd_ok      <= n_rd_ok;
    end

    // path buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            buf_mem[buf_wa] <= buf_wd;
        end
        if (buf_re) begin
            r_buf_q <= buf_mem[buf_ra];
        end
    end

    // slash table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (slash_we) begin
            slash_mem[slash_wa] <= r_len[AW-1:0];
        end
        if (slash_re) begin
            r_slash_q <= slash_mem[slash_ra];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_char <= r_rd_ok ? r_buf_q : '0;
            r_out_len  <= r_len;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - M_FIELD_W)'(0), r_out_ovf, PL_W'(r_out_len),
                              r_out_char};

endmodule

`default_nettype wire

[rtl/pcan_checker.sv]
`default_nettype none

module pcan_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_axis_tvalid,
    input wire logic                           i_s_axis_tready,
    input wire logic                           i_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [pcan_pkg::M_TDATA_W-1:0] i_m_axis_tdata
);
    import pcan_pkg::*;

    logic       s_acc, m_acc;
    logic [2:0] r_pending;

    assign s_acc = i_s_axis_tvalid && i_s_axis_tready;
    assign m_acc = i_m_axis_tvalid && i_m_axis_tready;

    // words accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= r_pending + {2'd0, s_acc} - {2'd0, m_acc};
        end
    end

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled result changed");

    // every result answers an accepted word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> r_pending != 3'd0)
        else $error("result without pending word");

    // input, engine and output hold three words at most
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("too many words in flight");

endmodule

bind path_canonicalizer_top pcan_checker u_pcan_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
